@@ rtl/rrfp_pkg.sv @@
// ----------------------------------------------------------------------------
// rrfp_pkg: shared types and constants of the range frame parser
// Transaction payloads, controller/datapath command and status, frame bytes.
// ----------------------------------------------------------------------------
package rrfp_pkg;

  localparam int unsigned RANGE_W  = 16;
  localparam int unsigned FRAMES_W = 5;
  localparam int unsigned BYTE_W   = 8;

  localparam logic [BYTE_W-1:0] HEAD_BYTE   = 8'hAA;
  localparam logic [BYTE_W-1:0] TAIL_BYTE   = 8'h55;
  localparam logic [BYTE_W-1:0] ID_HIGH_RST = 8'h0C;
  localparam logic [BYTE_W-1:0] ID_LOW_RST  = 8'h07;

  typedef enum logic [0:0] {
    CFG_ID_HIGH = 1'b0,
    CFG_ID_LOW  = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    MODE_BYTE = 1'b0,
    MODE_POLL = 1'b1
  } mode_e;

  typedef struct packed {
    logic              mode;
    logic [BYTE_W-1:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [RANGE_W-1:0]  range_cm;
    logic                valid_res;
    logic [FRAMES_W-1:0] frames_seen;
    logic                frames_dropped;
  } out_item_t;

  typedef struct packed {
    logic byte_en;
    logic poll_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } sts_t;

endpackage

@@ rtl/radar_range_frame_parser_unit.sv @@
// ----------------------------------------------------------------------------
// radar_range_frame_parser_unit: serial range frame parser with poll average
// Frames sensor bytes, checks id and checksum, averages ranges per poll.
// ----------------------------------------------------------------------------
// Data byte transaction: one per cycle while the input is not stalled, no result.
// End-of-poll transaction: after acceptance, one divide step per total bit, then
// one load; the result is valid once it is loaded.
// Input stalls from acceptance until the result is loaded, longer on output stall.
// Reset: parser idle, sums and counts zero, ids 0x0C and 0x07, no result.
module radar_range_frame_parser_unit #(
  parameter int unsigned MAX_FRAMES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  rrfp_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output rrfp_pkg::out_item_t out_data_o,
  input  logic                cfg_we_i,
  input  rrfp_pkg::cfg_idx_e  cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);
  import rrfp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rrfp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_mode_i   (in_data_i.mode),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rrfp_datapath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_data_i  (in_data_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_data_o (out_data_o)
  );

endmodule

@@ rtl/rrfp_ctrl.sv @@
// ----------------------------------------------------------------------------
// rrfp_ctrl: transaction sequencer of the range frame parser
// Accepts bytes and end-of-poll transactions, runs the divide, owns out valid.
// ----------------------------------------------------------------------------
module rrfp_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_mode_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output rrfp_pkg::cmd_t cmd_o,
  input  rrfp_pkg::sts_t sts_i
);
  import rrfp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_DIV  = 3'b010,
    S_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   in_take;
  logic   out_free;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign in_take     = in_valid_i & ~in_stall_o;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  always_comb begin
    state_d          = state_q;
    cmd_o            = '0;
    cmd_o.byte_en    = in_take & (in_mode_i == MODE_BYTE);
    cmd_o.poll_start = in_take & (in_mode_i == MODE_POLL);
    unique case (state_q)
      S_IDLE: begin
        if (cmd_o.poll_start) state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_poll_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_mode_i == MODE_POLL) |=> (state_q == S_DIV))
    else $error("end of poll did not start the divide");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV && sts_i.div_last) |=> (state_q == S_DONE))
    else $error("divide did not finish on its last step");

  a_load_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("loaded result not presented");

endmodule

@@ rtl/rrfp_datapath.sv @@
// ----------------------------------------------------------------------------
// rrfp_datapath: frame parser, range accumulator and serial divider
// Parses frames byte by byte, sums good ranges, divides once per poll.
// ----------------------------------------------------------------------------
module rrfp_datapath #(
  parameter int unsigned MAX_FRAMES = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rrfp_pkg::in_item_t  in_data_i,
  input  logic                cfg_we_i,
  input  rrfp_pkg::cfg_idx_e  cfg_idx_i,
  input  logic [7:0]          cfg_data_i,
  input  rrfp_pkg::cmd_t      cmd_i,
  output rrfp_pkg::sts_t      sts_o,
  output rrfp_pkg::out_item_t out_data_o
);
  import rrfp_pkg::*;

  localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned TOT_W  = RANGE_W + CNT_W;
  localparam int unsigned STEP_W = $clog2(TOT_W);

  typedef enum logic [13:0] {
    P_HEAD1 = 14'h0001,
    P_HEAD2 = 14'h0002,
    P_IDH   = 14'h0004,
    P_IDL   = 14'h0008,
    P_PAY1  = 14'h0010,
    P_PAY2  = 14'h0020,
    P_PAY3  = 14'h0040,
    P_PAY4  = 14'h0080,
    P_PAY5  = 14'h0100,
    P_PAY6  = 14'h0200,
    P_PAY7  = 14'h0400,
    P_CHK   = 14'h0800,
    P_TAIL1 = 14'h1000,
    P_TAIL2 = 14'h2000
  } parse_e;

  logic [BYTE_W-1:0] id_high_q, id_low_q;
  parse_e            pst_q, pst_d;
  logic [BYTE_W-1:0] csum_q, csum_d;
  logic [BYTE_W-1:0] rhi_q, rhi_d;
  logic [BYTE_W-1:0] rlo_q, rlo_d;
  logic [TOT_W-1:0]  tot_q, tot_d;
  logic [CNT_W-1:0]  fcnt_q, fcnt_d;
  logic              drop_q, drop_d;

  logic [TOT_W-1:0]  quo_q, quo_d;
  logic [CNT_W-1:0]  rem_q, rem_d;
  logic [CNT_W-1:0]  den_q, den_d;
  logic              pdrop_q, pdrop_d;
  logic [STEP_W-1:0] dcnt_q, dcnt_d;
  out_item_t         out_q;

  logic [BYTE_W-1:0]       c;
  logic [CNT_W:0]          shifted;
  logic [CNT_W:0]          diff;
  logic                    ge;
  logic [FRAMES_W+CNT_W-1:0] seen_ext;

  assign c = in_data_i.data_byte;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id_high_q <= ID_HIGH_RST;
      id_low_q  <= ID_LOW_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_ID_HIGH: id_high_q <= cfg_data_i;
        CFG_ID_LOW:  id_low_q  <= cfg_data_i;
        default:     id_low_q  <= id_low_q;
      endcase
    end
  end

  always_comb begin
    pst_d  = pst_q;
    csum_d = csum_q;
    rhi_d  = rhi_q;
    rlo_d  = rlo_q;
    tot_d  = tot_q;
    fcnt_d = fcnt_q;
    drop_d = drop_q;
    if (cmd_i.poll_start) begin
      pst_d  = P_HEAD1;
      csum_d = '0;
      rhi_d  = '0;
      rlo_d  = '0;
      tot_d  = '0;
      fcnt_d = '0;
      drop_d = 1'b0;
    end else if (cmd_i.byte_en) begin
      unique case (pst_q)
        P_HEAD2: begin
          if (c == HEAD_BYTE) begin
            csum_d = '0;
            rhi_d  = '0;
            rlo_d  = '0;
            pst_d  = P_IDH;
          end else begin
            pst_d = P_HEAD1;
          end
        end
        P_IDH: pst_d = (c == id_high_q) ? P_IDL : P_HEAD1;
        P_IDL: pst_d = (c == id_low_q) ? P_PAY1 : P_HEAD1;
        P_PAY1: begin
          csum_d = csum_q + c;
          pst_d  = P_PAY2;
        end
        P_PAY2: begin
          csum_d = csum_q + c;
          pst_d  = P_PAY3;
        end
        P_PAY3: begin
          csum_d = csum_q + c;
          rhi_d  = c;
          pst_d  = P_PAY4;
        end
        P_PAY4: begin
          csum_d = csum_q + c;
          rlo_d  = c;
          pst_d  = P_PAY5;
        end
        P_PAY5: begin
          csum_d = csum_q + c;
          pst_d  = P_PAY6;
        end
        P_PAY6: begin
          csum_d = csum_q + c;
          pst_d  = P_PAY7;
        end
        P_PAY7: begin
          csum_d = csum_q + c;
          pst_d  = P_CHK;
        end
        P_CHK:   pst_d = (c == csum_q) ? P_TAIL1 : P_HEAD1;
        P_TAIL1: pst_d = (c == TAIL_BYTE) ? P_TAIL2 : P_HEAD1;
        P_TAIL2: begin
          if (c == TAIL_BYTE) begin
            if (fcnt_q < CNT_W'(MAX_FRAMES)) begin
              tot_d  = tot_q + TOT_W'({rhi_q, rlo_q});
              fcnt_d = fcnt_q + CNT_W'(1);
            end else begin
              drop_d = 1'b1;
            end
          end
          pst_d = P_HEAD1;
        end
        default: pst_d = (c == HEAD_BYTE) ? P_HEAD2 : P_HEAD1;
      endcase
    end
  end

  // restoring divide, one quotient bit per step
  assign shifted = {rem_q, quo_q[TOT_W-1]};
  assign diff    = shifted - {1'b0, den_q};
  assign ge      = (shifted >= {1'b0, den_q});

  always_comb begin
    quo_d   = quo_q;
    rem_d   = rem_q;
    den_d   = den_q;
    pdrop_d = pdrop_q;
    dcnt_d  = dcnt_q;
    if (cmd_i.poll_start) begin
      quo_d   = tot_q;
      rem_d   = '0;
      den_d   = fcnt_q;
      pdrop_d = drop_q;
      dcnt_d  = STEP_W'(TOT_W - 1);
    end else if (cmd_i.div_step) begin
      rem_d  = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      quo_d  = {quo_q[TOT_W-2:0], ge};
      dcnt_d = dcnt_q - STEP_W'(1);
    end
  end

  assign sts_o.div_last = (dcnt_q == '0);
  assign seen_ext       = {{FRAMES_W{1'b0}}, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pst_q  <= P_HEAD1;
      csum_q <= '0;
      rhi_q  <= '0;
      rlo_q  <= '0;
      tot_q  <= '0;
      fcnt_q <= '0;
      drop_q <= 1'b0;
      dcnt_q <= '0;
    end else begin
      pst_q  <= pst_d;
      csum_q <= csum_d;
      rhi_q  <= rhi_d;
      rlo_q  <= rlo_d;
      tot_q  <= tot_d;
      fcnt_q <= fcnt_d;
      drop_q <= drop_d;
      dcnt_q <= dcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q   <= quo_d;
    rem_q   <= rem_d;
    den_q   <= den_d;
    pdrop_q <= pdrop_d;
    if (cmd_i.out_load) begin
      out_q.range_cm       <= (den_q != '0) ? quo_q[RANGE_W-1:0] : '0;
      out_q.valid_res      <= (den_q != '0);
      out_q.frames_seen    <= seen_ext[FRAMES_W-1:0];
      out_q.frames_dropped <= pdrop_q;
    end
  end

  assign out_data_o = out_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fcnt_q <= CNT_W'(MAX_FRAMES))
    else $error("frame count above its limit");

endmodule
